// ===== rtl/rgbxy_pkg.sv =====
// Package for the RGB to CIE xy converter: request types, matrix constants, curve helpers.
package rgbxy_pkg;

	localparam int CHROMA_W = 16;
	localparam int CODE_W   = 8;
	localparam int CODES    = 1 << CODE_W;

	// matrix coefficients in millionths
	localparam int unsigned M_XR = 649926;
	localparam int unsigned M_XG = 103455;
	localparam int unsigned M_XB = 197109;
	localparam int unsigned M_YR = 234327;
	localparam int unsigned M_YG = 743075;
	localparam int unsigned M_YB = 22598;
	localparam int unsigned M_ZG = 53077;
	localparam int unsigned M_ZB = 1035763;

	typedef struct packed {
		logic [CODE_W-1:0] red;
		logic [CODE_W-1:0] green;
		logic [CODE_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic [CHROMA_W-1:0] chroma_x;
		logic [CHROMA_W-1:0] chroma_y;
		logic                is_black;
	} xy_t;

	// round(micro / 1e6 * 2^frac)
	function automatic logic [63:0] coef_value(input int unsigned micro, input int unsigned frac);
		logic [63:0] m;
		m = 64'(micro);
		return ((m << frac) + 64'd500000) / 64'd1000000;
	endfunction

	// sRGB decode of one 8-bit code into a fraction with frac fraction bits
	function automatic logic [63:0] lin_value(input int unsigned v, input int unsigned frac);
		logic [63:0] vv;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] p;
		logic [63:0] lin;
		vv = 64'(v);
		if (vv <= 64'd10) begin
			return ((vv * 64'd100 << frac) + 64'd164730) / 64'd329460;
		end
		t  = ((vv * 64'd1000 + 64'd14025) << 30) / 64'd269025;
		s  = (t * t) >> 30;
		lo = 64'd0;
		hi = 64'd1 << 30;
		// fifth root of s by bisection
		for (int i = 0; i < 32; i++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				a   = (mid * mid) >> 30;
				b   = (a * a) >> 30;
				p   = (b * mid) >> 30;
				if (p <= s) begin
					lo = mid;
				end else begin
					hi = mid - 64'd1;
				end
			end
		end
		lin = (s * lo) >> 30;
		return (lin + (64'd1 << (29 - frac))) >> (30 - frac);
	endfunction

endpackage

// ===== rtl/rgb_to_cie_xy.sv =====
// RGB to CIE xy chromaticity converter: decode, matrix, and pipelined 16-bit divide.
// One request per cycle sustained while xy_ready stays high; a stalled result holds the pipeline.
// Throughput is set by the pipeline: table lookup, products, sums, total, then one
// restoring-division stage per quotient bit (16 stages), each fully registered.
// Each stage holds while its successor is full and stalled; empty stages still fill.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data registers are not reset.
module rgb_to_cie_xy
	import rgbxy_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_ready,
	input  pix_t pix,
	output logic xy_valid,
	input  logic xy_ready,
	output xy_t  xy
);

	// Widths: linear values reach 1.0 and coefficients reach just over 1.0.
	localparam int LW  = FRAC_BITS + 1;
	localparam int CW  = FRAC_BITS + 1;
	localparam int PW  = LW + CW;
	localparam int SW  = PW + 2;
	localparam int NST = 4 + CHROMA_W;   // table, products, XYZ, total, divide steps

	localparam logic [CW-1:0] C_XR = CW'(coef_value(M_XR, FRAC_BITS));
	localparam logic [CW-1:0] C_XG = CW'(coef_value(M_XG, FRAC_BITS));
	localparam logic [CW-1:0] C_XB = CW'(coef_value(M_XB, FRAC_BITS));
	localparam logic [CW-1:0] C_YR = CW'(coef_value(M_YR, FRAC_BITS));
	localparam logic [CW-1:0] C_YG = CW'(coef_value(M_YG, FRAC_BITS));
	localparam logic [CW-1:0] C_YB = CW'(coef_value(M_YB, FRAC_BITS));
	localparam logic [CW-1:0] C_ZG = CW'(coef_value(M_ZG, FRAC_BITS));
	localparam logic [CW-1:0] C_ZB = CW'(coef_value(M_ZB, FRAC_BITS));

	typedef logic [LW-1:0] lin_tab_t [CODES];

	function automatic lin_tab_t build_tab();
		lin_tab_t tab;
		for (int v = 0; v < CODES; v++) begin
			tab[v] = LW'(lin_value(v, FRAC_BITS));
		end
		return tab;
	endfunction

	// gamma decode table, evaluated at elaboration
	localparam lin_tab_t LIN_TAB = build_tab();

	// One division stage: partial remainders share the total as divisor.
	typedef struct packed {
		logic [SW-1:0]       rem_x;
		logic [SW-1:0]       rem_y;
		logic [SW-1:0]       den;
		logic [CHROMA_W-1:0] quo_x;
		logic [CHROMA_W-1:0] quo_y;
		logic                sat_x;
		logic                sat_y;
		logic                black;
	} div_stage_t;

	// ---------------------------------------------------------------
	// Flow control: a stage may load when it is empty or its successor
	// moves on. Valid bits travel with the data.
	// ---------------------------------------------------------------
	logic [NST-1:0] vld_q;
	logic [NST-1:0] vld_in;
	logic [NST-1:0] adv;

	always_comb begin
		vld_in[0] = pix_valid;
		for (int k = 1; k < NST; k++) begin
			vld_in[k] = vld_q[k-1];
		end
		adv[NST-1] = !vld_q[NST-1] || xy_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign pix_ready = adv[0];
	assign xy_valid  = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: gamma decode, three lookups into the constant table
	// ---------------------------------------------------------------
	logic [LW-1:0] lin_r_s1, lin_g_s1, lin_b_s1;

	always_ff @(posedge clk) begin
		if (adv[0] && vld_in[0]) begin
			lin_r_s1 <= LIN_TAB[pix.red];
			lin_g_s1 <= LIN_TAB[pix.green];
			lin_b_s1 <= LIN_TAB[pix.blue];
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: the eight nonzero matrix products, full precision
	// ---------------------------------------------------------------
	logic [PW-1:0] p_xr_s2, p_xg_s2, p_xb_s2;
	logic [PW-1:0] p_yr_s2, p_yg_s2, p_yb_s2;
	logic [PW-1:0] p_zg_s2, p_zb_s2;

	always_ff @(posedge clk) begin
		if (adv[1] && vld_in[1]) begin
			p_xr_s2 <= PW'(lin_r_s1) * PW'(C_XR);
			p_xg_s2 <= PW'(lin_g_s1) * PW'(C_XG);
			p_xb_s2 <= PW'(lin_b_s1) * PW'(C_XB);
			p_yr_s2 <= PW'(lin_r_s1) * PW'(C_YR);
			p_yg_s2 <= PW'(lin_g_s1) * PW'(C_YG);
			p_yb_s2 <= PW'(lin_b_s1) * PW'(C_YB);
			p_zg_s2 <= PW'(lin_g_s1) * PW'(C_ZG);
			p_zb_s2 <= PW'(lin_b_s1) * PW'(C_ZB);
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: X, Y, Z row sums
	// ---------------------------------------------------------------
	logic [SW-1:0] cx_s3, cy_s3, cz_s3;

	always_ff @(posedge clk) begin
		if (adv[2] && vld_in[2]) begin
			cx_s3 <= SW'(p_xr_s2) + SW'(p_xg_s2) + SW'(p_xb_s2);
			cy_s3 <= SW'(p_yr_s2) + SW'(p_yg_s2) + SW'(p_yb_s2);
			cz_s3 <= SW'(p_zg_s2) + SW'(p_zb_s2);
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: total X+Y+Z; seeds the divider (div_s[0])
	// ---------------------------------------------------------------
	div_stage_t div_s [CHROMA_W+1];

	always_ff @(posedge clk) begin
		if (adv[3] && vld_in[3]) begin
			div_s[0].rem_x <= cx_s3;
			div_s[0].rem_y <= cy_s3;
			div_s[0].den   <= cx_s3 + cy_s3 + cz_s3;
			div_s[0].quo_x <= '0;
			div_s[0].quo_y <= '0;
			div_s[0].sat_x <= 1'b0;
			div_s[0].sat_y <= 1'b0;
			div_s[0].black <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Stages 5..20: restoring division, one quotient bit per stage for
	// x and y side by side. The first step also flags a full share
	// (numerator not below the total) and a zero total.
	// ---------------------------------------------------------------
	for (genvar i = 0; i < CHROMA_W; i++) begin : g_div
		div_stage_t    nxt;
		logic [SW:0]   r2_x, r2_y;
		logic          ge_x, ge_y;

		always_comb begin
			r2_x = {div_s[i].rem_x, 1'b0};
			r2_y = {div_s[i].rem_y, 1'b0};
			ge_x = r2_x >= {1'b0, div_s[i].den};
			ge_y = r2_y >= {1'b0, div_s[i].den};
			nxt       = div_s[i];
			nxt.rem_x = ge_x ? SW'(r2_x - {1'b0, div_s[i].den}) : r2_x[SW-1:0];
			nxt.rem_y = ge_y ? SW'(r2_y - {1'b0, div_s[i].den}) : r2_y[SW-1:0];
			nxt.quo_x = {div_s[i].quo_x[CHROMA_W-2:0], ge_x};
			nxt.quo_y = {div_s[i].quo_y[CHROMA_W-2:0], ge_y};
			if (i == 0) begin
				nxt.sat_x = div_s[i].rem_x >= div_s[i].den;
				nxt.sat_y = div_s[i].rem_y >= div_s[i].den;
				nxt.black = div_s[i].den == '0;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[4+i] && vld_in[4+i]) begin
				div_s[i+1] <= nxt;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result: black forces zeros, a full share saturates
	// ---------------------------------------------------------------
	always_comb begin
		xy.is_black = div_s[CHROMA_W].black;
		if (div_s[CHROMA_W].black) begin
			xy.chroma_x = '0;
			xy.chroma_y = '0;
		end else begin
			xy.chroma_x = div_s[CHROMA_W].sat_x ? '1 : div_s[CHROMA_W].quo_x;
			xy.chroma_y = div_s[CHROMA_W].sat_y ? '1 : div_s[CHROMA_W].quo_y;
		end
	end

endmodule

// ===== tb/rgb_xy_checker.sv =====
// Checker for the RGB to CIE xy converter: predicts each result and compares what comes out.
module rgb_xy_checker
	import rgbxy_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	input  logic pix_ready,
	input  pix_t pix,
	input  logic xy_valid,
	input  logic xy_ready,
	input  xy_t  xy,
	output int   errors,
	output int   pending
);

	logic [63:0] lin_tab [CODES];
	logic [63:0] k_xr, k_xg, k_xb, k_yr, k_yg, k_yb, k_zg, k_zb;
	xy_t         xy_due [$];

	// round(micro / 1e6 * 2^FRAC_BITS)
	function automatic logic [63:0] coef_q(input int unsigned micro);
		return ((64'(micro) << FRAC_BITS) + 64'd500000) / 64'd1000000;
	endfunction

	// sRGB curve: linear toe below code 11, else the 2.4 power via fifth root of t^2
	function automatic logic [63:0] srgb_decode(input int unsigned code);
		logic [63:0] c, t, s, lo, hi, mid, sq, p4, p5, lin;
		c = 64'(code);
		if (c <= 64'd10)
			return ((c * 64'd100) << FRAC_BITS) + 64'd164730 == 0 ? 64'd0 :
				(((c * 64'd100) << FRAC_BITS) + 64'd164730) / 64'd329460;
		t  = ((c * 64'd1000 + 64'd14025) << 30) / 64'd269025;
		s  = (t * t) >> 30;
		lo = 64'd0;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			sq  = (mid * mid) >> 30;
			p4  = (sq * sq) >> 30;
			p5  = (p4 * mid) >> 30;
			if (p5 <= s)
				lo = mid;
			else
				hi = mid - 64'd1;
		end
		lin = (s * lo) >> 30;
		return (lin + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
	endfunction

	// floor(num * 2^16 / den), saturating at full share
	function automatic logic [CHROMA_W-1:0] share16(input logic [63:0] num,
			input logic [63:0] den);
		logic [63:0]         r;
		logic [CHROMA_W-1:0] q;
		if (num >= den)
			return '1;
		r = num;
		q = '0;
		for (int i = 0; i < CHROMA_W; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r    = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic xy_t chroma_of(input pix_t p);
		logic [63:0] lr, lg, lb, cx, cy, cz, total;
		xy_t         res;
		lr    = lin_tab[p.red];
		lg    = lin_tab[p.green];
		lb    = lin_tab[p.blue];
		cx    = lr * k_xr + lg * k_xg + lb * k_xb;
		cy    = lr * k_yr + lg * k_yg + lb * k_yb;
		cz    = lg * k_zg + lb * k_zb;
		total = cx + cy + cz;
		if (total == 64'd0) begin
			res.chroma_x = '0;
			res.chroma_y = '0;
			res.is_black = 1'b1;
		end else begin
			res.chroma_x = share16(cx, total);
			res.chroma_y = share16(cy, total);
			res.is_black = 1'b0;
		end
		return res;
	endfunction

	initial begin
		errors  = 0;
		pending = 0;
		k_xr = coef_q(M_XR);
		k_xg = coef_q(M_XG);
		k_xb = coef_q(M_XB);
		k_yr = coef_q(M_YR);
		k_yg = coef_q(M_YG);
		k_yb = coef_q(M_YB);
		k_zg = coef_q(M_ZG);
		k_zb = coef_q(M_ZB);
		for (int v = 0; v < CODES; v++)
			lin_tab[v] = srgb_decode(v);
	end

	always @(posedge clk) begin
		xy_t want;
		if (arst_n) begin
			if (pix_valid && pix_ready)
				xy_due.insert(xy_due.size(), chroma_of(pix));
			if (xy_valid && xy_ready) begin
				if (xy_due.size() == 0) begin
					$display("%0t: unexpected result x=%h y=%h black=%b", $time,
						xy.chroma_x, xy.chroma_y, xy.is_black);
					errors = errors + 1;
				end else begin
					want = xy_due.pop_front();
					if (xy.chroma_x !== want.chroma_x) begin
						$display("%0t: chroma_x expected %h actual %h", $time,
							want.chroma_x, xy.chroma_x);
						errors = errors + 1;
					end
					if (xy.chroma_y !== want.chroma_y) begin
						$display("%0t: chroma_y expected %h actual %h", $time,
							want.chroma_y, xy.chroma_y);
						errors = errors + 1;
					end
					if (xy.is_black !== want.is_black) begin
						$display("%0t: is_black expected %b actual %b", $time,
							want.is_black, xy.is_black);
						errors = errors + 1;
					end
				end
			end
			pending = xy_due.size();
		end
	end

endmodule

// ===== tb/tb_rgb_to_cie_xy.sv =====
// Testbench top for the RGB to CIE xy converter: clock, reset, request stimulus and verdict.
module tb_rgb_to_cie_xy;
	import rgbxy_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam int RAND_REQS = 850;
	// watchdog limit, kept with a wide margin over the slowest legal run
	localparam int CYCLE_LIMIT = 500000;
	// pipeline depth is 20; drain a bit longer to catch stray results
	localparam int DRAIN = 60;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_ready;
	pix_t pix;
	logic xy_valid;
	logic xy_ready;
	xy_t  xy;
	int   errors;
	int   pending;
	int   cycles;
	bit   calm;   // when set, neither side idles

	rgb_to_cie_xy #(.FRAC_BITS(FRAC_BITS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix),
		.xy_valid (xy_valid),
		.xy_ready (xy_ready),
		.xy       (xy)
	);

	rgb_xy_checker #(.FRAC_BITS(FRAC_BITS)) chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix),
		.xy_valid (xy_valid),
		.xy_ready (xy_ready),
		.xy       (xy),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly zero or short, now and then a long hole.
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Choose anew between calm stretches and choppy ones, each of random length.
	initial begin
		calm = 1'b0;
		forever begin
			repeat ($urandom_range(150, 500)) @(posedge clk);
			calm <= ($urandom_range(0, 3) == 0);
		end
	end

	// Cycle count and watchdog.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles = cycles + 1;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: ready drops for runs of random length.
	initial begin
		int hold;
		hold     = 0;
		xy_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold = hold - 1;
				xy_ready <= 1'b0;
			end else begin
				hold = idle_len();
				xy_ready <= (hold == 0);
			end
		end
	end

	// One request: optional idle gap, then valid held until the handshake.
	// Ready is looked at on the falling edge, where it is settled, so the
	// request is known to go in at the following rising edge.
	task automatic send_pix(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int   gap;
		pix_t p;
		p.red   = r;
		p.green = g;
		p.blue  = b;
		gap     = idle_len();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		@(negedge clk);
		while (!pix_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Code near the toe/power threshold of the sRGB curve.
	function automatic logic [7:0] near_knee();
		return 8'($urandom_range(8, 14));
	endfunction

	function automatic logic [7:0] pick_extreme();
		int r;
		r = $urandom_range(0, 2);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int          kind;
		logic [7:0]  v;
		arst_n    = 1'b0;
		pix_valid = 1'b0;
		pix       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: black, white, primaries, secondaries, darkest codes, the curve threshold, gray and mixes.
		send_pix(8'd0,   8'd0,   8'd0);
		send_pix(8'd255, 8'd255, 8'd255);
		send_pix(8'd255, 8'd0,   8'd0);
		send_pix(8'd0,   8'd255, 8'd0);
		send_pix(8'd0,   8'd0,   8'd255);
		send_pix(8'd255, 8'd255, 8'd0);
		send_pix(8'd0,   8'd255, 8'd255);
		send_pix(8'd255, 8'd0,   8'd255);
		send_pix(8'd1,   8'd0,   8'd0);
		send_pix(8'd0,   8'd1,   8'd0);
		send_pix(8'd0,   8'd0,   8'd1);
		send_pix(8'd1,   8'd1,   8'd1);
		send_pix(8'd10,  8'd10,  8'd10);
		send_pix(8'd11,  8'd11,  8'd11);
		send_pix(8'd10,  8'd0,   8'd0);
		send_pix(8'd11,  8'd0,   8'd0);
		send_pix(8'd0,   8'd10,  8'd11);
		send_pix(8'd0,   8'd0,   8'd0);
		send_pix(8'd128, 8'd128, 8'd128);
		send_pix(8'd254, 8'd1,   8'd127);
		send_pix(8'd170, 8'd85,  8'd0);

		// Random: mixed classes of color so dark, gray and saturated cases recur.
		for (int n = 0; n < RAND_REQS; n++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				send_pix(8'($urandom), 8'($urandom), 8'($urandom));
			end else if (kind < 58) begin
				send_pix(8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
					8'($urandom_range(0, 20)));
			end else if (kind < 73) begin
				send_pix(pick_extreme(), pick_extreme(), pick_extreme());
			end else if (kind < 85) begin
				v = 8'($urandom);
				send_pix(v, v, v);
			end else if (kind < 97) begin
				send_pix(near_knee(), near_knee(), near_knee());
			end else begin
				send_pix(8'd0, 8'd0, 8'd0);
			end
		end
		pix_valid <= 1'b0;

		// Drain: wait for every predicted result, then a bit more.
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
